@@ rtl/bmhq_pkg.sv @@
// Package for the binary max-heap queue: payload widths, operation and status codes,
// and default parameter values. No dependencies.
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int KEY_W        = 16;
  localparam int TAG_W        = 16;
  localparam int CNT_W        = 7;
  localparam int STAT_W       = 2;
  localparam int DEF_CAPACITY = 64;
  localparam int DEF_KEY_BITS = 16;

  typedef enum logic {
    OP_INS = 1'b0,
    OP_EXT = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

endpackage

@@ rtl/bmhq_in_if.sv @@
// Request channel of the binary max-heap queue: valid/ready plus operation payload.
// Depends on bmhq_pkg for field widths.
`timescale 1ns / 1ps

interface bmhq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [bmhq_pkg::KEY_W-1:0]  key;
  logic [bmhq_pkg::TAG_W-1:0]  tag;

  modport source (output valid, output mode, output key, output tag, input ready);
  modport sink   (input valid, input mode, input key, input tag, output ready);
endinterface

@@ rtl/bmhq_out_if.sv @@
// Response channel of the binary max-heap queue: valid/ready plus result payload.
// Depends on bmhq_pkg for field widths.
`timescale 1ns / 1ps

interface bmhq_out_if;
  logic                         valid;
  logic                         ready;
  logic [bmhq_pkg::STAT_W-1:0]  status;
  logic [bmhq_pkg::KEY_W-1:0]   out_key;
  logic [bmhq_pkg::TAG_W-1:0]   out_tag;
  logic [bmhq_pkg::CNT_W-1:0]   count;

  modport source (output valid, output status, output out_key, output out_tag,
                  output count, input ready);
  modport sink   (input valid, input status, input out_key, input out_tag,
                  input count, output ready);
endinterface

@@ rtl/bmhq_cell.sv @@
// One heap level: entry memory for that level, a read stage and a decide stage.
// Passes insert/extract tokens down the chain and writes promoted entries up one level.
// Depends on bmhq_pkg; struct types come from the top level.
`timescale 1ns / 1ps

module bmhq_cell #(
  parameter int  LVL    = 0,
  parameter int  LEVELS = 7,
  parameter type ent_t  = logic,
  parameter type tok_t  = logic,
  parameter type wr_t   = logic,
  parameter type prb_t  = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  tok_t tok_i,
  output tok_t tok_o,
  input  prb_t prb_i,
  input  wr_t  uw_i,
  output wr_t  uw_o,
  output ent_t rd_a_o,
  output ent_t rd_b_o,
  output logic done_o
);

  localparam int AW = (LVL > 0) ? LVL : 1;
  localparam int MD = 1 << AW;
  localparam int CW = LEVELS;
  localparam int PW = LEVELS - 1;
  localparam int DW = $clog2(LEVELS);
  localparam logic [AW-1:0] AMASK  = AW'((1 << LVL) - 1);
  localparam logic [AW-1:0] RBIT   = AW'(1) & AMASK;
  localparam logic [DW-1:0] LVL_D  = DW'(LVL);
  localparam logic [CW-1:0] LBASE  = CW'(1 << LVL);
  localparam bit            IS_LAST = (LVL == LEVELS - 1);

  ent_t mem_q [MD];
  ent_t rd_a_q, rd_b_q;
  tok_t s_q, tok_q, tok_d;
  logic [AW-1:0] s_ipos_q, s_left_q;

  logic [DW-1:0] shamt;
  logic [CW-1:0] path;
  logic [AW-1:0] ipos, left, right, ppos, up_addr, addr_a, addr_b;

  logic          loc_we;
  logic [AW-1:0] loc_addr;
  ent_t          loc_data;

  logic [CW-1:0] lnum;
  logic          lex, rex, lt, rt, take;
  logic [$bits(rd_a_q.key)-1:0] cmpk;
  logic [AW-1:0] s_right;

  // read address selection
  always_comb begin
    shamt = tok_i.dep - LVL_D;
    path  = tok_i.num >> shamt;
    ipos  = AW'(path) & AMASK;
    left  = AW'({tok_i.pos, 1'b0}) & AMASK;
    right = left | RBIT;
    ppos  = AW'(prb_i.num) & AMASK;
    if (prb_i.valid) begin
      addr_a = '0;
      addr_b = ppos;
    end else begin
      addr_a = (tok_i.op == bmhq_pkg::OP_INS) ? ipos : left;
      addr_b = right;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_q[addr_a];
    rd_b_q <= mem_q[addr_b];
  end

  always_ff @(posedge clk_i) begin
    s_ipos_q <= ipos;
    s_left_q <= left;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q   <= '0;
      tok_q <= '0;
    end else begin
      s_q   <= tok_i;
      tok_q <= tok_d;
    end
  end

  // decide stage
  always_comb begin
    s_right  = s_left_q | RBIT;
    lnum     = LBASE | CW'(s_left_q);
    lex      = (lnum <= s_q.num);
    rex      = (lnum < s_q.num);
    lt       = lex && (rd_a_q.key > s_q.ent.key);
    cmpk     = lt ? rd_a_q.key : s_q.ent.key;
    rt       = rex && (rd_b_q.key > cmpk);
    take     = s_q.disp || (rd_a_q.key < s_q.ent.key);

    tok_d       = s_q;
    tok_d.valid = 1'b0;
    loc_we      = 1'b0;
    loc_addr    = s_ipos_q;
    loc_data    = s_q.ent;
    uw_o        = '0;
    uw_o.pos    = s_q.pos;
    uw_o.ent    = s_q.ent;
    done_o      = 1'b0;

    if (s_q.valid) begin
      if (s_q.op == bmhq_pkg::OP_INS) begin
        if (s_q.dep == LVL_D) begin
          loc_we = 1'b1;
          done_o = 1'b1;
        end else begin
          tok_d.valid = 1'b1;
          if (take) begin
            loc_we     = 1'b1;
            tok_d.ent  = rd_a_q;
            tok_d.disp = 1'b1;
          end
        end
      end else begin
        uw_o.valid = 1'b1;
        if (rt || lt) begin
          uw_o.ent  = rt ? rd_b_q : rd_a_q;
          loc_addr  = rt ? s_right : s_left_q;
          tok_d.pos = PW'(loc_addr);
          if (IS_LAST) begin
            loc_we = 1'b1;
            done_o = 1'b1;
          end else begin
            tok_d.valid = 1'b1;
          end
        end else begin
          done_o = 1'b1;
        end
      end
    end
  end

  assign up_addr = AW'(uw_i.pos) & AMASK;

  always_ff @(posedge clk_i) begin
    if (uw_i.valid) begin
      mem_q[up_addr] <= uw_i.ent;
    end else if (loc_we) begin
      mem_q[loc_addr] <= loc_data;
    end
  end

  assign tok_o  = tok_q;
  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

@@ rtl/binary_max_heap_queue.sv @@
// Binary max-heap priority queue of (key, tag) entries, built as a chain of level cells.
// Depends on bmhq_pkg, bmhq_in_if, bmhq_out_if and bmhq_cell.
`timescale 1ns / 1ps

// One operation is in flight at a time; a request is taken only while the block is idle.
// Each heap level is a cell with its own memory, and an operation token walks down the
// chain one level at a time, with a read and then a compare and write at each level.
// There are LEVELS = clog2(CAPACITY+1) levels. Errors (extract on empty, insert on full)
// go straight to the result without entering the chain. The result register frees the
// response side, so a waiting response stalls the block only when the next result is
// ready.

module binary_max_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = bmhq_pkg::DEF_KEY_BITS
) (
  input logic          clk_i,
  input logic          rst_ni,
  bmhq_in_if.sink      req_i,
  bmhq_out_if.source   rsp_o
);

  localparam int LEVELS = $clog2(CAPACITY + 1);
  localparam int CW     = LEVELS;
  localparam int PW     = LEVELS - 1;
  localparam int DW     = $clog2(LEVELS);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  typedef struct packed {
    logic [KEY_BITS-1:0]        key;
    logic [bmhq_pkg::TAG_W-1:0] tag;
  } ent_t;

  typedef struct packed {
    logic            valid;
    bmhq_pkg::op_e   op;
    logic            disp;
    ent_t            ent;
    logic [CW-1:0]   num;
    logic [DW-1:0]   dep;
    logic [PW-1:0]   pos;
  } tok_t;

  typedef struct packed {
    logic          valid;
    logic [PW-1:0] pos;
    ent_t          ent;
  } wr_t;

  typedef struct packed {
    logic          valid;
    logic [CW-1:0] num;
  } prb_t;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [DW-1:0] lvl_q, lvl_d;
  tok_t          inj_q, inj_d;
  prb_t          prb;

  bmhq_pkg::status_e          res_status_q, res_status_d;
  logic [bmhq_pkg::KEY_W-1:0] res_key_q, res_key_d;
  logic [bmhq_pkg::TAG_W-1:0] res_tag_q, res_tag_d;

  logic                        out_valid_q, out_valid_d, out_load;
  logic [bmhq_pkg::STAT_W-1:0] out_status_q;
  logic [bmhq_pkg::KEY_W-1:0]  out_key_q;
  logic [bmhq_pkg::TAG_W-1:0]  out_tag_q;
  logic [bmhq_pkg::CNT_W-1:0]  out_count_q;

  tok_t          tok_in  [LEVELS];
  tok_t          tok_out [LEVELS];
  wr_t           uw_s    [LEVELS+1];
  ent_t          rd_a    [LEVELS];
  ent_t          rd_b    [LEVELS];
  logic [LEVELS-1:0] done_s;
  logic          any_done;

  bmhq_pkg::op_e in_op;
  logic          req_acc;
  logic [CW-1:0] sel_num;
  logic [DW-1:0] sel_dep;
  tok_t          ins_tok, ext_tok;

  assign in_op   = bmhq_pkg::op_e'(req_i.mode);
  assign req_acc = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign any_done = |done_s;

  // 1-based heap number of the slot touched and its depth
  always_comb begin
    sel_num = (in_op == bmhq_pkg::OP_EXT) ? count_q : count_q + CW'(1);
    sel_dep = '0;
    for (int i = 0; i < CW; i++) begin
      if (sel_num[i]) sel_dep = DW'(i);
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    lvl_d        = lvl_q;
    inj_d        = inj_q;
    inj_d.valid  = 1'b0;
    prb          = '0;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_tag_d    = res_tag_q;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          res_status_d = bmhq_pkg::STAT_OK;
          res_key_d    = '0;
          res_tag_d    = '0;
          if (in_op == bmhq_pkg::OP_INS) begin
            if (count_q == CAP_C) begin
              res_status_d = bmhq_pkg::STAT_FULL;
              state_d      = S_FIN;
            end else begin
              count_d       = count_q + CW'(1);
              inj_d.valid   = 1'b1;
              inj_d.op      = bmhq_pkg::OP_INS;
              inj_d.disp    = 1'b0;
              inj_d.ent.key = KEY_BITS'(req_i.key);
              inj_d.ent.tag = req_i.tag;
              inj_d.num     = sel_num;
              inj_d.dep     = sel_dep;
              inj_d.pos     = '0;
              state_d       = S_RUN;
            end
          end else begin
            if (count_q == '0) begin
              res_status_d = bmhq_pkg::STAT_EMPTY;
              state_d      = S_FIN;
            end else begin
              count_d   = count_q - CW'(1);
              prb.valid = 1'b1;
              prb.num   = sel_num;
              lvl_d     = sel_dep;
              state_d   = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        res_key_d = bmhq_pkg::KEY_W'(rd_a[0].key);
        res_tag_d = rd_a[0].tag;
        if (count_q == '0) begin
          state_d = S_FIN;
        end else begin
          inj_d.valid = 1'b1;
          inj_d.op    = bmhq_pkg::OP_EXT;
          inj_d.disp  = 1'b0;
          inj_d.ent   = rd_b[lvl_q];
          inj_d.num   = count_q;
          inj_d.dep   = '0;
          inj_d.pos   = '0;
          state_d     = S_RUN;
        end
      end
      S_RUN: begin
        if (any_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      inj_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      inj_q       <= inj_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q        <= lvl_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_tag_q    <= res_tag_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_key_q    <= res_key_q;
      out_tag_q    <= res_tag_q;
      out_count_q  <= bmhq_pkg::CNT_W'(count_q);
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.status  = out_status_q;
  assign rsp_o.out_key = out_key_q;
  assign rsp_o.out_tag = out_tag_q;
  assign rsp_o.count   = out_count_q;

  // inserts enter at the root cell, extracts at level one (hole at the root)
  always_comb begin
    ins_tok       = inj_q;
    ins_tok.valid = inj_q.valid && (inj_q.op == bmhq_pkg::OP_INS);
    ext_tok       = inj_q;
    ext_tok.valid = inj_q.valid && (inj_q.op == bmhq_pkg::OP_EXT);
  end

  assign tok_in[0]      = ins_tok;
  assign tok_in[1]      = tok_out[0].valid ? tok_out[0] : ext_tok;
  assign uw_s[LEVELS]   = '0;

  for (genvar g = 2; g < LEVELS; g++) begin : g_link
    assign tok_in[g] = tok_out[g-1];
  end

  for (genvar g = 0; g < LEVELS; g++) begin : g_cell
    bmhq_cell #(
      .LVL    (g),
      .LEVELS (LEVELS),
      .ent_t  (ent_t),
      .tok_t  (tok_t),
      .wr_t   (wr_t),
      .prb_t  (prb_t)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok_in[g]),
      .tok_o  (tok_out[g]),
      .prb_i  (prb),
      .uw_i   (uw_s[g+1]),
      .uw_o   (uw_s[g]),
      .rd_a_o (rd_a[g]),
      .rd_b_o (rd_b[g]),
      .done_o (done_s[g])
    );
  end

  a_no_tok_off_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tok_out[LEVELS-1].valid)
    else $error("token left the last level");

  a_no_write_above_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !uw_s[0].valid)
    else $error("write above the root level");

  a_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(done_s))
    else $error("more than one level finished at once");

  a_done_only_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_RUN) |-> (done_s == '0))
    else $error("level finished outside a running transaction");

  a_ext_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (in_op == bmhq_pkg::OP_EXT) && (count_q != '0))
      |=> (count_q == $past(count_q) - CW'(1)))
    else $error("extract did not shrink the count");

endmodule

@@ dv/binary_max_heap_queue_tb.sv @@
// Self-checking testbench for binary_max_heap_queue: random insert/extract traffic with
// handshake gaps on both sides, checked against a max-heap predictor in a scoreboard class.
// Depends on bmhq_pkg, bmhq_in_if, bmhq_out_if and the binary_max_heap_queue RTL.
`timescale 1ns / 1ps

module binary_max_heap_queue_tb;

  localparam int CAPACITY    = bmhq_pkg::DEF_CAPACITY;
  localparam int KEY_W       = bmhq_pkg::KEY_W;
  localparam int TAG_W       = bmhq_pkg::TAG_W;
  localparam int CNT_W       = bmhq_pkg::CNT_W;
  localparam int ITEMS       = 1250;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    bmhq_pkg::status_e status;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic [CNT_W-1:0]  count;
  } heap_rsp_t;

  class heap_scoreboard;
    logic [KEY_W-1:0] keys [CAPACITY];
    logic [TAG_W-1:0] tags [CAPACITY];
    int               held;
    heap_rsp_t        expected_q [$];
    int               mismatches;
    int               n_checked;
    int               n_ins;
    int               n_ext;
    int               n_empty;
    int               n_full;
    int               peak_held;

    function new();
      held = 0;
      mismatches = 0;
      n_checked = 0;
      n_ins = 0;
      n_ext = 0;
      n_empty = 0;
      n_full = 0;
      peak_held = 0;
    endfunction

    function void swap_slots(int a, int b);
      logic [KEY_W-1:0] k;
      logic [TAG_W-1:0] t;
      k = keys[a];
      t = tags[a];
      keys[a] = keys[b];
      tags[a] = tags[b];
      keys[b] = k;
      tags[b] = t;
    endfunction

    function void note_request(bmhq_pkg::op_e op, logic [KEY_W-1:0] k,
                               logic [TAG_W-1:0] t);
      heap_rsp_t exp_rsp;
      int        pos;
      int        best;
      int        lc;
      int        rc;
      exp_rsp = '{status: bmhq_pkg::STAT_OK, key: '0, tag: '0, count: '0};
      if (op == bmhq_pkg::OP_INS) begin
        if (held >= CAPACITY) begin
          exp_rsp.status = bmhq_pkg::STAT_FULL;
          n_full++;
        end else begin
          keys[held] = k;
          tags[held] = t;
          pos = held;
          held++;
          n_ins++;
          while (pos > 0 && keys[(pos - 1) / 2] < keys[pos]) begin
            swap_slots(pos, (pos - 1) / 2);
            pos = (pos - 1) / 2;
          end
        end
      end else begin
        if (held == 0) begin
          exp_rsp.status = bmhq_pkg::STAT_EMPTY;
          n_empty++;
        end else begin
          exp_rsp.key = keys[0];
          exp_rsp.tag = tags[0];
          held--;
          n_ext++;
          keys[0] = keys[held];
          tags[0] = tags[held];
          pos = 0;
          while (pos < held) begin
            best = pos;
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            if (lc < held && keys[lc] > keys[best]) best = lc;
            if (rc < held && keys[rc] > keys[best]) best = rc;
            if (best == pos) break;
            swap_slots(pos, best);
            pos = best;
          end
        end
      end
      if (held > peak_held) peak_held = held;
      exp_rsp.count = CNT_W'(held);
      expected_q = {expected_q, exp_rsp};
    endfunction

    function void check_response(heap_rsp_t got);
      heap_rsp_t exp_rsp;
      n_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected response status=%0d key=%h tag=%h count=%0d",
                   $realtime, got.status, got.key, got.tag, got.count);
        return;
      end
      exp_rsp = expected_q.pop_front();
      if (got.status !== exp_rsp.status || got.key !== exp_rsp.key ||
          got.tag !== exp_rsp.tag || got.count !== exp_rsp.count) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"%0t: response %0d exp status=%0d key=%h tag=%h count=%0d,",
                    " got status=%0d key=%h tag=%h count=%0d"},
                   $realtime, n_checked, exp_rsp.status, exp_rsp.key, exp_rsp.tag,
                   exp_rsp.count, got.status, got.key, got.tag, got.count);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bmhq_in_if  req_if ();
  bmhq_out_if rsp_if ();

  heap_scoreboard heap_sb = new();

  int send_quiet = 0;
  int rsp_quiet  = 0;
  int n_sent     = 0;

  binary_max_heap_queue u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready)
      heap_sb.note_request(bmhq_pkg::op_e'(req_if.mode), req_if.key, req_if.tag);
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      heap_sb.check_response(heap_rsp_t'{status: bmhq_pkg::status_e'(rsp_if.status),
                                         key: rsp_if.out_key, tag: rsp_if.out_tag,
                                         count: rsp_if.count});
  end

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Extremes and a narrow band for ties, otherwise full range.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 45) return KEY_W'($urandom_range(0, 7));
    return KEY_W'($urandom());
  endfunction

  task automatic send_op(bmhq_pkg::op_e op, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
    int gap;
    req_if.valid <= 1'b1;
    req_if.mode  <= op;
    req_if.key   <= k;
    req_if.tag   <= t;
    do @(posedge clk_i); while (!req_if.ready);
    n_sent++;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Receiver; one long hold-off lets the block back up into the request side.
  initial begin : rsp_drain
    int gap;
    int taken;
    taken = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken == HOLD_AT) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        gap = pick_gap(rsp_quiet);
        if (gap > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      taken++;
    end
  end

  initial begin : stimulus
    int            phase_len;
    int            ins_pct;
    int            phase_no;
    bmhq_pkg::op_e op;
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.mode  <= bmhq_pkg::OP_INS;
    req_if.key   <= '0;
    req_if.tag   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty extract, key extremes, parent and child ties, drain to empty
    send_op(bmhq_pkg::OP_EXT, '1, '1);
    send_op(bmhq_pkg::OP_INS, '0, '0);
    send_op(bmhq_pkg::OP_INS, '1, '1);
    send_op(bmhq_pkg::OP_INS, '1, 16'h1234);
    send_op(bmhq_pkg::OP_INS, 16'h8000, 16'h5555);
    send_op(bmhq_pkg::OP_INS, 16'h8000, 16'hAAAA);
    send_op(bmhq_pkg::OP_INS, 16'h0001, 16'h0001);
    send_op(bmhq_pkg::OP_INS, '0, 16'h7FFF);
    repeat (8) send_op(bmhq_pkg::OP_EXT, 16'hA5A5, 16'h5A5A);
    send_op(bmhq_pkg::OP_INS, 16'h0005, 16'h0100);
    send_op(bmhq_pkg::OP_INS, 16'h0005, 16'h0200);
    send_op(bmhq_pkg::OP_INS, 16'h0005, 16'h0300);
    send_op(bmhq_pkg::OP_INS, 16'h0005, 16'h0400);
    repeat (4) send_op(bmhq_pkg::OP_EXT, '0, '0);

    // random phases: first a fill past capacity, then a drain past empty, then mixed
    phase_no = 0;
    while (n_sent < ITEMS) begin
      case (phase_no)
        0: begin
          ins_pct = 100;
          phase_len = CAPACITY + 8;
        end
        1: begin
          ins_pct = 0;
          phase_len = CAPACITY + 8;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: ins_pct = 85;
            1: ins_pct = 15;
            2: ins_pct = 50;
            default: ins_pct = 60;
          endcase
          phase_len = $urandom_range(20, 90);
        end
      endcase
      phase_no++;
      repeat (phase_len) begin
        op = ($urandom_range(0, 99) < ins_pct) ? bmhq_pkg::OP_INS : bmhq_pkg::OP_EXT;
        send_op(op, pick_key(), TAG_W'($urandom()));
      end
    end
    req_if.valid <= 1'b0;

    while (heap_sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Run covered %0d transactions: %0d inserts, %0d extracts,",
             n_sent, heap_sb.n_ins, heap_sb.n_ext);
    $display("%0d inserts on a full heap, %0d extracts on an empty one, peak %0d of %0d",
             heap_sb.n_full, heap_sb.n_empty, heap_sb.peak_held, CAPACITY);
    if (heap_sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ binary_max_heap_queue.f @@
rtl/bmhq_pkg.sv
rtl/bmhq_in_if.sv
rtl/bmhq_out_if.sv
rtl/bmhq_cell.sv
rtl/binary_max_heap_queue.sv
dv/binary_max_heap_queue_tb.sv
